/* hdl/tnpl_pkg.sv */
// Shared types, register codes and constants of the top-n pixel locator.
package tnpl_pkg;

   localparam int COORD_BITS     = 12;
   localparam int CSR_DATA_BITS  = 12;
   localparam int CSR_INDEX_BITS = 2;
   localparam int KEEP_CFG_BITS  = 5;

   localparam int DEF_MAX_KEEP   = 16;
   localparam int DEF_MAX_COLS   = 3840;
   localparam int DEF_MAX_ROWS   = 2160;
   localparam int DEF_PIXEL_BITS = 24;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_ROWS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_COLS = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEEP_COUNT = 2'd2;

   localparam logic [COORD_BITS-1:0]    RST_FRAME_ROWS = 12'd2160;
   localparam logic [COORD_BITS-1:0]    RST_FRAME_COLS = 12'd3840;
   localparam logic [KEEP_CFG_BITS-1:0] RST_KEEP_COUNT = 5'd16;

   // frame geometry, already clamped, as last column / last row
   typedef struct packed {
      logic [COORD_BITS-1:0] rows_m1;
      logic [COORD_BITS-1:0] cols_m1;
   } cfg_type;

   typedef struct packed {
      logic rank_en;   // rank the accepted pixel and advance the counters
      logic shift_en;  // head slot delivered, move the list up one place
      logic clear_en;  // last rank delivered, empty the list
   } cmd_type;

   typedef struct packed {
      logic frame_end; // counters sit on the last pixel of the frame
   } stat_type;

   // zero acts as one, above the limit acts as the limit; returns value minus one
   function automatic logic [COORD_BITS-1:0] clamp_m1(input logic [COORD_BITS-1:0] v,
                                                      input logic [COORD_BITS-1:0] hi);
      logic [COORD_BITS-1:0] c;
      if (v == '0)
         c = COORD_BITS'(1);
      else if (v > hi)
         c = hi;
      else
         c = v;
      return c - COORD_BITS'(1);
   endfunction

endpackage

/* hdl/tnpl_csr.sv */
// Configuration registers with range clamping.
module tnpl_csr #(
   parameter int MAX_KEEP = 16,
   parameter int MAX_COLS = 3840,
   parameter int MAX_ROWS = 2160,
   localparam int KEEP_W  = $clog2(MAX_KEEP + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [tnpl_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tnpl_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output tnpl_pkg::cfg_type                    cfg,
   output logic [KEEP_W-1:0]                    keep_n
);
   import tnpl_pkg::*;

   localparam int KW = (KEEP_W > KEEP_CFG_BITS) ? KEEP_W : KEEP_CFG_BITS;

   logic [COORD_BITS-1:0]    rows_ff, rows_in;
   logic [COORD_BITS-1:0]    cols_ff, cols_in;
   logic [KEEP_CFG_BITS-1:0] keep_ff, keep_in;
   logic [KW-1:0]            keep_ext;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      keep_in = keep_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_ROWS: rows_in = csr_wdata[COORD_BITS-1:0];
            CSR_FRAME_COLS: cols_in = csr_wdata[COORD_BITS-1:0];
            CSR_KEEP_COUNT: keep_in = csr_wdata[KEEP_CFG_BITS-1:0];
            default: ;  // unknown index: write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= RST_FRAME_ROWS;
         cols_ff <= RST_FRAME_COLS;
         keep_ff <= RST_KEEP_COUNT;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         keep_ff <= keep_in;
      end
   end

   assign cfg.rows_m1 = clamp_m1(rows_ff, COORD_BITS'(MAX_ROWS));
   assign cfg.cols_m1 = clamp_m1(cols_ff, COORD_BITS'(MAX_COLS));

   assign keep_ext = KW'(keep_ff);
   assign keep_n   = (keep_ext == '0)           ? KEEP_W'(1) :
                     (keep_ext > KW'(MAX_KEEP)) ? KEEP_W'(MAX_KEEP) :
                                                  KEEP_W'(keep_ext);

endmodule

/* hdl/tnpl_ctrl.sv */
// Controller: pixel intake versus ranked list readout.
module tnpl_ctrl #(
   parameter int MAX_KEEP = 16,
   localparam int KEEP_W  = $clog2(MAX_KEEP + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_last_rank,
   input  logic [KEEP_W-1:0]   keep_n,
   input  tnpl_pkg::stat_type  stat,
   output tnpl_pkg::cmd_type   cmd
);
   import tnpl_pkg::*;

   localparam logic ST_RUN  = 1'b0;
   localparam logic ST_DUMP = 1'b1;

   logic              state_ff, state_in;
   logic [KEEP_W-1:0] idx_ff, idx_in;
   logic              last;
   logic              out_take;

   assign req_stall     = (state_ff == ST_DUMP);
   assign rsp_valid     = (state_ff == ST_DUMP);
   assign last          = (idx_ff == keep_n - KEEP_W'(1));
   assign rsp_last_rank = last;
   assign out_take      = rsp_valid && !rsp_stall;

   assign cmd.rank_en  = req_valid && !req_stall;
   assign cmd.shift_en = out_take && !last;
   assign cmd.clear_en = out_take && last;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (cmd.rank_en && stat.frame_end) begin
               state_in = ST_DUMP;
               idx_in   = '0;
            end
         end
         ST_DUMP: begin
            if (out_take) begin
               if (last)
                  state_in = ST_RUN;
               else
                  idx_in = idx_ff + KEEP_W'(1);
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

/* hdl/tnpl_datapath.sv */
// Datapath: raster counters and the sorted top-n slot list.
module tnpl_datapath #(
   parameter int MAX_KEEP   = 16,
   parameter int PIXEL_BITS = 24,
   localparam int KEEP_W    = $clog2(MAX_KEEP + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [PIXEL_BITS-1:0]             pixel,
   input  tnpl_pkg::cfg_type                 cfg,
   input  logic [KEEP_W-1:0]                 keep_n,
   input  tnpl_pkg::cmd_type                 cmd,
   output tnpl_pkg::stat_type                stat,
   output logic [tnpl_pkg::COORD_BITS-1:0]   head_col,
   output logic [tnpl_pkg::COORD_BITS-1:0]   head_row
);
   import tnpl_pkg::*;

   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic                  end_col, end_row;

   assign end_col        = (col_ff >= cfg.cols_m1);
   assign end_row        = (row_ff >= cfg.rows_m1);
   assign stat.frame_end = end_col && end_row;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.rank_en) begin
         if (!end_col) begin
            col_in = col_ff + COORD_BITS'(1);
         end else begin
            col_in = '0;
            row_in = end_row ? '0 : row_ff + COORD_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // slot list, slot 0 holds the highest value
   logic [PIXEL_BITS-1:0] val_ff [MAX_KEEP];
   logic [COORD_BITS-1:0] scol_ff[MAX_KEEP];
   logic [COORD_BITS-1:0] srow_ff[MAX_KEEP];
   logic [PIXEL_BITS-1:0] val_in [MAX_KEEP];
   logic [COORD_BITS-1:0] scol_in[MAX_KEEP];
   logic [COORD_BITS-1:0] srow_in[MAX_KEEP];
   logic [PIXEL_BITS-1:0] up_val [MAX_KEEP];
   logic [COORD_BITS-1:0] up_col [MAX_KEEP];
   logic [COORD_BITS-1:0] up_row [MAX_KEEP];
   logic [PIXEL_BITS-1:0] dn_val [MAX_KEEP];
   logic [COORD_BITS-1:0] dn_col [MAX_KEEP];
   logic [COORD_BITS-1:0] dn_row [MAX_KEEP];
   logic [MAX_KEEP-1:0]   in_use, gt, ahead;

   for (genvar j = 0; j < MAX_KEEP; j++) begin : g_slot
      assign in_use[j] = (KEEP_W'(j) < keep_n);
      assign gt[j]     = in_use[j] && (pixel > val_ff[j]);

      if (j == 0) begin : g_first
         assign ahead[j]  = 1'b0;
         assign dn_val[j] = '0;
         assign dn_col[j] = '0;
         assign dn_row[j] = '0;
      end else begin : g_rest
         assign ahead[j]  = |gt[j-1:0];
         assign dn_val[j] = val_ff[j-1];
         assign dn_col[j] = scol_ff[j-1];
         assign dn_row[j] = srow_ff[j-1];
      end

      if (j == MAX_KEEP - 1) begin : g_tail
         assign up_val[j] = '0;
         assign up_col[j] = '0;
         assign up_row[j] = '0;
      end else begin : g_body
         assign up_val[j] = val_ff[j+1];
         assign up_col[j] = scol_ff[j+1];
         assign up_row[j] = srow_ff[j+1];
      end

      always_comb begin
         val_in[j]  = val_ff[j];
         scol_in[j] = scol_ff[j];
         srow_in[j] = srow_ff[j];
         if (cmd.clear_en) begin
            val_in[j]  = '0;
            scol_in[j] = '0;
            srow_in[j] = '0;
         end else if (cmd.shift_en) begin
            val_in[j]  = up_val[j];
            scol_in[j] = up_col[j];
            srow_in[j] = up_row[j];
         end else if (cmd.rank_en) begin
            if (gt[j] && !ahead[j]) begin
               val_in[j]  = pixel;
               scol_in[j] = col_ff;
               srow_in[j] = row_ff;
            end else if (ahead[j] && in_use[j]) begin
               val_in[j]  = dn_val[j];
               scol_in[j] = dn_col[j];
               srow_in[j] = dn_row[j];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[j]  <= '0;
            scol_ff[j] <= '0;
            srow_ff[j] <= '0;
         end else begin
            val_ff[j]  <= val_in[j];
            scol_ff[j] <= scol_in[j];
            srow_ff[j] <= srow_in[j];
         end
      end
   end

   assign head_col = scol_ff[0];
   assign head_row = srow_ff[0];

endmodule

/* hdl/top_n_pixel_locator.sv */
// Top level of the top-n pixel locator.
//
// Usage:
//  - Request channel (req_valid / req_stall / req_pixel): one packed pixel per
//    request, in raster order. A pixel is ranked in the cycle it is accepted,
//    so the block takes one pixel per clock while the frame runs.
//  - Response channel (rsp_valid / rsp_stall / rsp_coord_x / rsp_coord_y /
//    rsp_last_rank): after the last pixel of a frame the block reports
//    keep_count coordinate pairs, highest value first, the final one marked
//    by rsp_last_rank. Unfilled ranks report (0,0).
//  - Readout: the first response is valid the cycle after the last pixel is
//    accepted; ranks go out one per cycle while the receiver does not stall,
//    and a stall holds the current rank. The slot list shifts up one place
//    per delivered response, so the head slot is the output register and
//    holds steady under stall.
//  - During readout req_stall is high; intake resumes the cycle after the
//    last rank is taken, with an empty list and counters at zero.
//  - CSR port: frame_rows, frame_cols, keep_count; write only while idle.
//  - Reset (synchronous, active high) empties the list, zeroes the counters
//    and restores the default geometry.
module top_n_pixel_locator #(
   parameter int MAX_KEEP   = tnpl_pkg::DEF_MAX_KEEP,
   parameter int MAX_COLS   = tnpl_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS   = tnpl_pkg::DEF_MAX_ROWS,
   parameter int PIXEL_BITS = tnpl_pkg::DEF_PIXEL_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [PIXEL_BITS-1:0]               req_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tnpl_pkg::COORD_BITS-1:0]     rsp_coord_x,
   output logic [tnpl_pkg::COORD_BITS-1:0]     rsp_coord_y,
   output logic                                rsp_last_rank,
   input  logic                                csr_wr_en,
   input  logic [tnpl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tnpl_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import tnpl_pkg::*;

   localparam int KEEP_W = $clog2(MAX_KEEP + 1);

   cfg_type           cfg;
   logic [KEEP_W-1:0] keep_n;
   cmd_type           cmd;
   stat_type          stat;

   // clamped geometry and rank count
   tnpl_csr #(
      .MAX_KEEP (MAX_KEEP),
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .keep_n    (keep_n)
   );

   // handshakes and readout sequencing
   tnpl_ctrl #(
      .MAX_KEEP (MAX_KEEP)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_last_rank (rsp_last_rank),
      .keep_n        (keep_n),
      .stat          (stat),
      .cmd           (cmd)
   );

   // counters and sorted slots; head slot drives the response payload
   tnpl_datapath #(
      .MAX_KEEP   (MAX_KEEP),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .pixel    (req_pixel),
      .cfg      (cfg),
      .keep_n   (keep_n),
      .cmd      (cmd),
      .stat     (stat),
      .head_col (rsp_coord_x),
      .head_row (rsp_coord_y)
   );

endmodule

/* hdl/tnpl_checker.sv */
// Port-level checker for the top-n pixel locator, bound to the top level.
module tnpl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [tnpl_pkg::COORD_BITS-1:0] rsp_coord_x,
   input logic [tnpl_pkg::COORD_BITS-1:0] rsp_coord_y,
   input logic                            rsp_last_rank
);
   import tnpl_pkg::*;

   // no pixel is taken while the list is read out
   a_stall_in_dump: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted during readout");

   // readout runs without gaps until the marked rank
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_rank) |=> rsp_valid)
      else $error("readout broke off before last rank");

   // the marked rank ends the readout
   a_end_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_rank) |=> !rsp_valid)
      else $error("response after last rank");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_coord_x)
                                    && $stable(rsp_coord_y) && $stable(rsp_last_rank)))
      else $error("stalled response changed");

endmodule

bind top_n_pixel_locator tnpl_checker u_tnpl_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench for top_n_pixel_locator: pixel frames with random gaps, checked by a top-n predictor.
module tb_top;
   import tnpl_pkg::*;

   localparam int PIX_W         = DEF_PIXEL_BITS;
   localparam int KEEP_SLOTS    = DEF_MAX_KEEP;
   localparam int RANDOM_PIXELS = 314;
   localparam int CYCLE_LIMIT   = 200000;
   // readout starts the cycle after the last pixel; this margin follows its last rank
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_LIMIT   = 5000;
   // index with no register behind it, writes there must be dropped
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  is_last;
   } rank_type;

   // Tracks the ranked list and counters, queues the coordinates due at frame end.
   class locator_scoreboard;
      logic [PIX_W-1:0]      top_val [KEEP_SLOTS];
      logic [COORD_BITS-1:0] top_x [KEEP_SLOTS];
      logic [COORD_BITS-1:0] top_y [KEEP_SLOTS];
      logic [COORD_BITS-1:0] col_cnt;
      logic [COORD_BITS-1:0] row_cnt;
      logic [COORD_BITS-1:0] rows_cfg;
      logic [COORD_BITS-1:0] cols_cfg;
      logic [KEEP_CFG_BITS-1:0] keep_cfg;
      rank_type ranks_due[$];
      int errors;

      function new();
         errors = 0;
         rows_cfg = RST_FRAME_ROWS;
         cols_cfg = RST_FRAME_COLS;
         keep_cfg = RST_KEEP_COUNT;
         col_cnt = '0;
         row_cnt = '0;
         clear_list();
      endfunction

      function void clear_list();
         for (int s = 0; s < KEEP_SLOTS; s++) begin
            top_val[s] = '0;
            top_x[s] = '0;
            top_y[s] = '0;
         end
      endfunction

      // zero acts as one, anything above the limit acts as the limit
      function int clamp_size(int v, int hi);
         int c;
         c = v;
         if (v == 0)
            c = 1;
         else if (v > hi)
            c = hi;
         return c;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] data);
         case (index)
            CSR_FRAME_ROWS: rows_cfg = data;
            CSR_FRAME_COLS: cols_cfg = data;
            CSR_KEEP_COUNT: keep_cfg = data[KEEP_CFG_BITS-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return ranks_due.size();
      endfunction

      function void note_pixel(logic [PIX_W-1:0] value);
         int  n;
         int  rows;
         int  cols;
         int  k;
         bit  placed;
         rank_type r;
         n = clamp_size(keep_cfg, KEEP_SLOTS);
         rows = clamp_size(rows_cfg, DEF_MAX_ROWS);
         cols = clamp_size(cols_cfg, DEF_MAX_COLS);
         placed = 1'b0;
         // strict compare keeps the earlier pixel ahead on ties
         for (int j = 0; j < n; j++) begin
            if (!placed && value > top_val[j]) begin
               for (k = n - 1; k > j; k--) begin
                  top_val[k] = top_val[k-1];
                  top_x[k] = top_x[k-1];
                  top_y[k] = top_y[k-1];
               end
               top_val[j] = value;
               top_x[j] = col_cnt;
               top_y[j] = row_cnt;
               placed = 1'b1;
            end
         end
         // "at or beyond" compare: a shrunken size wraps a counter at once
         if (int'(col_cnt) < cols - 1) begin
            col_cnt = col_cnt + 1'b1;
         end else begin
            col_cnt = '0;
            if (int'(row_cnt) < rows - 1) begin
               row_cnt = row_cnt + 1'b1;
            end else begin
               row_cnt = '0;
               for (k = 0; k < n; k++) begin
                  r.x = top_x[k];
                  r.y = top_y[k];
                  r.is_last = (k == n - 1);
                  ranks_due.push_back(r);
               end
               clear_list();
            end
         end
      endfunction

      function void check_rank(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                               logic is_last);
         rank_type want;
         if (ranks_due.size() == 0) begin
            $display("%0t: response with none due: x=%0d y=%0d last=%0b",
                     $time, x, y, is_last);
            errors++;
         end else begin
            want = ranks_due.pop_front();
            if (x !== want.x) begin
               $display("%0t: coord_x expected %0d, actual %0d", $time, want.x, x);
               errors++;
            end
            if (y !== want.y) begin
               $display("%0t: coord_y expected %0d, actual %0d", $time, want.y, y);
               errors++;
            end
            if (is_last !== want.is_last) begin
               $display("%0t: last_rank expected %0b, actual %0b", $time, want.is_last, is_last);
               errors++;
            end
         end
      endfunction
   endclass

   // clock, reset and DUT ports; every input starts at a known value
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [PIX_W-1:0] req_pixel = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [COORD_BITS-1:0] rsp_coord_x;
   logic [COORD_BITS-1:0] rsp_coord_y;
   logic rsp_last_rank;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   bit steady = 1'b0;               // no idling on either side while set
   int cycle_count = 0;
   logic [PIX_W-1:0] prev_pixel = '0;
   locator_scoreboard sb = new();

   top_n_pixel_locator u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pixel(req_pixel),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_coord_x(rsp_coord_x),
      .rsp_coord_y(rsp_coord_y),
      .rsp_last_rank(rsp_last_rank),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // hard stop in case a handshake never completes
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("top_n_pixel_locator regression: fail");
         $finish;
      end
   end

   // receiver: random stall, changed only at the falling edge
   always @(negedge clock) begin
      rsp_stall = !steady && ($urandom_range(99) < 24);
   end

   // single monitor at the rising edge: accepted requests feed the predictor,
   // accepted responses are checked against the oldest due rank
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_pixel(req_pixel);
         if (rsp_valid && !rsp_stall)
            sb.check_rank(rsp_coord_x, rsp_coord_y, rsp_last_rank);
      end
   end

   // one request; called at a falling edge, returns at a falling edge
   task automatic send_pixel(input logic [PIX_W-1:0] value);
      while (!steady && $urandom_range(99) < 24)
         @(negedge clock);
      req_valid = 1'b1;
      req_pixel = value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // wait for every due rank, then let the block fall idle
   task automatic settle();
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // CSR writes only happen with the block idle
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      settle();
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wdata = data;
      sb.write_reg(index, data);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // mix of zeros, full scale, repeats for ties, small and wide values
   function automatic logic [PIX_W-1:0] pick_pixel();
      logic [PIX_W-1:0] p;
      case ($urandom_range(9))
         0: p = '0;
         1: p = '1;
         2: p = prev_pixel;
         3, 4: p = PIX_W'($urandom_range(1, 15));
         default: p = PIX_W'($urandom());
      endcase
      prev_pixel = p;
      return p;
   endfunction

   initial begin
      int sent;
      int count;
      int rows;
      int cols;
      int keep;
      int drain;

      repeat (5) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // one row, widest frame, keep count clamped down to all slots;
      // the spare index must be ignored
      write_reg(CSR_FRAME_ROWS, 12'd0);
      write_reg(CSR_FRAME_COLS, 12'd3840);
      write_reg(CSR_KEEP_COUNT, 12'd31);
      write_reg(CSR_SPARE, 12'hABC);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h000000);
      send_pixel(24'h000001);
      send_pixel(24'hFFFFFF);   // tie: the first one stays ahead
      send_pixel(24'h800000);
      // shrink the row below the column counter: next pixel closes the frame
      write_reg(CSR_FRAME_COLS, 12'd5);
      send_pixel(24'h123456);

      // oversized rows, zero columns and zero keep count, then sizes moved mid-frame
      write_reg(CSR_FRAME_ROWS, 12'hFFF);
      write_reg(CSR_FRAME_COLS, 12'd0);
      write_reg(CSR_KEEP_COUNT, 12'd0);
      send_pixel(24'd5);
      send_pixel(24'd7);
      send_pixel(24'd7);
      write_reg(CSR_KEEP_COUNT, 12'd2);
      write_reg(CSR_FRAME_ROWS, 12'd2);
      send_pixel(24'd9);

      // keep count cut and raised inside one 2x3 frame; upper data bits set
      write_reg(CSR_FRAME_ROWS, 12'd2);
      write_reg(CSR_FRAME_COLS, 12'd3);
      write_reg(CSR_KEEP_COUNT, 12'hFE4);
      send_pixel(24'd10);
      send_pixel(24'd20);
      send_pixel(24'd30);
      write_reg(CSR_KEEP_COUNT, 12'd1);
      send_pixel(24'd25);
      send_pixel(24'd40);
      write_reg(CSR_KEEP_COUNT, 12'd3);
      send_pixel(24'd15);

      // random phases: mostly whole frames of small random geometry
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         rows = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
         cols = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
         keep = ($urandom_range(9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
         write_reg(CSR_FRAME_ROWS, CSR_DATA_BITS'(rows));
         write_reg(CSR_FRAME_COLS, CSR_DATA_BITS'(cols));
         write_reg(CSR_KEEP_COUNT, {7'($urandom()), 5'(keep)});
         count = (rows == 0 ? 1 : rows) * (cols == 0 ? 1 : cols) * $urandom_range(1, 3);
         for (int i = 0; i < count && sent < RANDOM_PIXELS; i++) begin
            // a stretch with no idling on either side
            steady = (sent >= 140 && sent < 220);
            // occasional broken frame: geometry or keep count moved mid-frame
            if ($urandom_range(99) < 3) begin
               case ($urandom_range(3))
                  0: write_reg(CSR_FRAME_ROWS, CSR_DATA_BITS'($urandom_range(0, 6)));
                  1: write_reg(CSR_FRAME_COLS, CSR_DATA_BITS'($urandom_range(0, 6)));
                  2: write_reg(CSR_KEEP_COUNT, CSR_DATA_BITS'($urandom_range(0, 20)));
                  default: write_reg(CSR_SPARE, CSR_DATA_BITS'($urandom()));
               endcase
            end
            // sometimes hold requests until the readout has fully drained
            if (sb.pending() != 0 && $urandom_range(3) == 0)
               settle();
            send_pixel(pick_pixel());
            sent++;
         end
      end
      steady = 1'b0;

      // drain with a bound; anything still due counts as a failure
      drain = 0;
      while (sb.pending() != 0 && drain < DRAIN_LIMIT) begin
         @(negedge clock);
         drain++;
      end
      if (sb.pending() != 0) begin
         $display("%0t: %0d ranks never delivered", $time, sb.pending());
         sb.errors++;
      end
      repeat (16) @(negedge clock);

      if (sb.errors == 0)
         $display("top_n_pixel_locator regression: pass");
      else
         $display("top_n_pixel_locator regression: fail");
      $finish;
   end

endmodule
